@@ hdl/clock_calendar_set_editor_defines.svh @@
// Assertion macros for the clock/calendar set editor.
// Included by the top level; no other dependencies.
`ifndef CLOCK_CALENDAR_SET_EDITOR_DEFINES_SVH
`define CLOCK_CALENDAR_SET_EDITOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CCSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock_calendar_set_editor: assertion failed");
`define CCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock_calendar_set_editor: assertion failed");
`else
`define CCSE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/ccse_pkg.sv @@
// Types, codes and helpers for the clock/calendar set editor.
// No dependencies.
package ccse_pkg;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned MODE_W     = 3;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_LEFT  = 3'd1,
        MODE_RIGHT = 3'd2,
        MODE_UP    = 3'd3,
        MODE_DOWN  = 3'd4,
        MODE_LOAD  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        SEL_HOUR   = 3'd0,
        SEL_MINUTE = 3'd1,
        SEL_PM     = 3'd2,
        SEL_MONTH  = 3'd3,
        SEL_DAY    = 3'd4,
        SEL_YEAR   = 3'd5
    } sel_t;

    // Load fields as packed in the input tdata, hour in the low bits.
    typedef struct packed {
        logic [6:0] year;
        logic [4:0] day;
        logic [3:0] month;
        logic       pm;
        logic [5:0] minute;
        logic [3:0] hour;
    } load_t;

    typedef struct packed {
        logic [3:0] hour;
        logic [5:0] minute;
        logic       pm;
        logic [3:0] month;
        logic [4:0] day;
        logic [6:0] year;
        sel_t       sel;
    } state_t;

    // Month length; an invalid month counts as January. Leap when year mod 4 is 0.
    function automatic logic [4:0] days_of(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] n;
        begin
            case (month)
                4'd2:    n = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
                4'd4:    n = 5'd30;
                4'd6:    n = 5'd30;
                4'd9:    n = 5'd30;
                4'd11:   n = 5'd30;
                default: n = 5'd31;
            endcase
            return n;
        end
    endfunction

endpackage

@@ hdl/clock_calendar_set_editor.sv @@
// Clock/calendar set editor. Every accepted item (tick, left, right, up, down, load
// or a no-op spare) updates the settings and yields exactly one result item in the
// cycle after, held in an output register. The update is a single pass of logic
// between the settings registers and that output register, so one item is accepted
// in every cycle while the result side is ready; a stalled result blocks only the
// next item. Timeout compares the saturating 32-bit idle counter, after the item's
// update, against timeout_ticks. Uses ccse_pkg, ccse_step and the defines header.
`include "clock_calendar_set_editor_defines.svh"

module clock_calendar_set_editor
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [31:0]                        cfg_wr_data,   // timeout_ticks
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // load_hour[3:0] load_minute[9:4] load_pm[10] load_month[14:11]
    // load_day[19:15] load_year[26:20]
    input  logic [ccse_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [ccse_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[2:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hour[3:0] minute[9:4] pm[10] month[14:11] day[19:15] year[26:20]
    // selected[29:27] hour_24[34:30] timed_out[35]
    output logic [ccse_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    ccse_pkg::state_t                  state_reg;
    ccse_pkg::state_t                  state_next;
    ccse_pkg::mode_t                   mode;
    ccse_pkg::load_t                   load;
    logic [31:0]                       timeout_reg;
    logic [31:0]                       idle_count_reg;
    logic [31:0]                       idle_count_next;
    logic                              m_valid_reg;
    logic [ccse_pkg::OUT_DATA_W-1:0]   m_data_reg;
    logic [ccse_pkg::OUT_DATA_W-1:0]   m_data_next;
    logic [4:0]                        hour_24;
    logic                              timed_out;
    logic                              s_acc;
    logic [4:0]                        day_max;
    logic                              edit_acc;

    assign mode          = ccse_pkg::mode_t'(s_axis_tuser);
    assign load          = ccse_pkg::load_t'(s_axis_tdata[$bits(ccse_pkg::load_t)-1:0]);
    assign s_axis_tready = ~m_valid_reg | m_axis_tready;
    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    ccse_step u_step
    (
        .cur     (state_reg),
        .mode    (mode),
        .load    (load),
        .nxt     (state_next),
        .hour_24 (hour_24)
    );

    always_comb
    begin
        case (mode)
            ccse_pkg::MODE_TICK:
                idle_count_next = (idle_count_reg == 32'hFFFF_FFFF) ?
                                  idle_count_reg : idle_count_reg + 32'd1;
            ccse_pkg::MODE_LEFT,
            ccse_pkg::MODE_RIGHT,
            ccse_pkg::MODE_UP,
            ccse_pkg::MODE_DOWN,
            ccse_pkg::MODE_LOAD:
                idle_count_next = 32'd0;
            default:
                idle_count_next = idle_count_reg;
        endcase
    end

    assign timed_out   = idle_count_next > timeout_reg;
    assign m_data_next = {4'b0, timed_out, hour_24, state_next.sel, state_next.year,
                          state_next.day, state_next.month, state_next.pm,
                          state_next.minute, state_next.hour};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '{hour: 4'd12, minute: 6'd0, pm: 1'b0, month: 4'd1,
                                day: 5'd1, year: 7'd0, sel: ccse_pkg::SEL_HOUR};
            idle_count_reg <= 32'd0;
            timeout_reg    <= ccse_pkg::TIMEOUT_RESET;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (s_acc)
            begin
                state_reg      <= state_next;
                idle_count_reg <= idle_count_next;
                m_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign day_max  = ccse_pkg::days_of(state_reg.month, state_reg.year);
    assign edit_acc = s_acc && mode != ccse_pkg::MODE_TICK &&
                      s_axis_tuser <= ccse_pkg::MODE_LOAD;

    `CCSE_ASSERT_IMPL(a_day_nonzero, clk, rst_n, 1'b1, state_reg.day != 5'd0)
    `CCSE_ASSERT_IMPL(a_day_max, clk, rst_n, 1'b1, state_reg.day <= day_max)
    `CCSE_ASSERT_IMPL(a_sel_range, clk, rst_n, 1'b1, (state_reg.sel <= ccse_pkg::SEL_YEAR))
    `CCSE_ASSERT_NEXT(a_result_after_item, clk, rst_n, s_acc, m_valid_reg)
    `CCSE_ASSERT_NEXT(a_idle_clear, clk, rst_n, edit_acc, (idle_count_reg == 32'd0))

endmodule

@@ hdl/ccse_step.sv @@
// Next-state logic of the set editor: selection, field stepping with carries,
// load clamping and day clamping, plus 24-hour conversion. Uses ccse_pkg.
module ccse_step
(
    input  ccse_pkg::state_t cur,
    input  ccse_pkg::mode_t  mode,
    input  ccse_pkg::load_t  load,
    output ccse_pkg::state_t nxt,
    output logic [4:0]       hour_24
);

    ccse_pkg::state_t st;
    logic [4:0]       dim_cur;
    logic [4:0]       dim_new;

    assign dim_cur = ccse_pkg::days_of(cur.month, cur.year);
    assign dim_new = ccse_pkg::days_of(st.month, st.year);

    always_comb
    begin
        st = cur;
        case (mode)
            ccse_pkg::MODE_LEFT:
            begin
                case (cur.sel)
                    ccse_pkg::SEL_MINUTE: st.sel = ccse_pkg::SEL_HOUR;
                    ccse_pkg::SEL_PM:     st.sel = ccse_pkg::SEL_MINUTE;
                    ccse_pkg::SEL_MONTH:  st.sel = ccse_pkg::SEL_PM;
                    ccse_pkg::SEL_DAY:    st.sel = ccse_pkg::SEL_MONTH;
                    ccse_pkg::SEL_YEAR:   st.sel = ccse_pkg::SEL_DAY;
                    default:              st.sel = ccse_pkg::SEL_YEAR;
                endcase
            end
            ccse_pkg::MODE_RIGHT:
            begin
                case (cur.sel)
                    ccse_pkg::SEL_HOUR:   st.sel = ccse_pkg::SEL_MINUTE;
                    ccse_pkg::SEL_MINUTE: st.sel = ccse_pkg::SEL_PM;
                    ccse_pkg::SEL_PM:     st.sel = ccse_pkg::SEL_MONTH;
                    ccse_pkg::SEL_MONTH:  st.sel = ccse_pkg::SEL_DAY;
                    ccse_pkg::SEL_DAY:    st.sel = ccse_pkg::SEL_YEAR;
                    default:              st.sel = ccse_pkg::SEL_HOUR;
                endcase
            end
            ccse_pkg::MODE_UP:
            begin
                case (cur.sel)
                    ccse_pkg::SEL_HOUR:
                        st.hour = (cur.hour >= 4'd12) ? 4'd1 : cur.hour + 4'd1;
                    ccse_pkg::SEL_MINUTE:
                        st.minute = (cur.minute >= 6'd59) ? 6'd0 : cur.minute + 6'd1;
                    ccse_pkg::SEL_PM:
                        st.pm = ~cur.pm;
                    ccse_pkg::SEL_MONTH:
                        st.month = (cur.month >= 4'd12) ? 4'd1 : cur.month + 4'd1;
                    ccse_pkg::SEL_DAY:
                    begin
                        if (cur.day >= dim_cur)
                        begin
                            st.day = 5'd1;
                            if (cur.month >= 4'd12)
                            begin
                                st.month = 4'd1;
                                if (cur.year < 7'd99)
                                begin
                                    st.year = cur.year + 7'd1;
                                end
                            end
                            else
                            begin
                                st.month = cur.month + 4'd1;
                            end
                        end
                        else
                        begin
                            st.day = cur.day + 5'd1;
                        end
                    end
                    ccse_pkg::SEL_YEAR:
                        st.year = (cur.year < 7'd99) ? cur.year + 7'd1 : cur.year;
                    default: ;
                endcase
            end
            ccse_pkg::MODE_DOWN:
            begin
                case (cur.sel)
                    ccse_pkg::SEL_HOUR:
                        st.hour = (cur.hour <= 4'd1) ? 4'd12 : cur.hour - 4'd1;
                    ccse_pkg::SEL_MINUTE:
                        st.minute = (cur.minute == 6'd0) ? 6'd59 : cur.minute - 6'd1;
                    ccse_pkg::SEL_PM:
                        st.pm = ~cur.pm;
                    ccse_pkg::SEL_MONTH:
                        st.month = (cur.month <= 4'd1) ? 4'd12 : cur.month - 4'd1;
                    ccse_pkg::SEL_DAY:
                    begin
                        if (cur.day <= 5'd1)
                        begin
                            if (cur.month <= 4'd1)
                            begin
                                st.month = 4'd12;
                                if (cur.year > 7'd0)
                                begin
                                    st.year = cur.year - 7'd1;
                                end
                            end
                            else
                            begin
                                st.month = cur.month - 4'd1;
                            end
                            // the clamp below trims this to the new month's last day
                            st.day = 5'd31;
                        end
                        else
                        begin
                            st.day = cur.day - 5'd1;
                        end
                    end
                    ccse_pkg::SEL_YEAR:
                        st.year = (cur.year > 7'd0) ? cur.year - 7'd1 : cur.year;
                    default: ;
                endcase
            end
            ccse_pkg::MODE_LOAD:
            begin
                st.hour   = (load.hour == 4'd0 || load.hour > 4'd12) ? 4'd12 : load.hour;
                st.minute = (load.minute > 6'd59) ? 6'd59 : load.minute;
                st.pm     = load.pm;
                st.month  = (load.month == 4'd0) ? 4'd1 :
                            ((load.month > 4'd12) ? 4'd12 : load.month);
                st.day    = (load.day == 5'd0) ? 5'd1 : load.day;
                st.year   = (load.year > 7'd99) ? 7'd99 : load.year;
            end
            default: ;
        endcase
    end

    // Day clamp to the month length after every change.
    always_comb
    begin
        nxt = st;
        if (st.day > dim_new)
        begin
            nxt.day = dim_new;
        end
        else if (st.day == 5'd0)
        begin
            nxt.day = 5'd1;
        end
    end

    always_comb
    begin
        if (nxt.pm)
        begin
            hour_24 = (nxt.hour == 4'd12) ? 5'd12 : {1'b0, nxt.hour} + 5'd12;
        end
        else
        begin
            hour_24 = (nxt.hour == 4'd12) ? 5'd0 : {1'b0, nxt.hour};
        end
    end

endmodule

@@ tb/clock_calendar_set_editor_test.sv @@
// Self-checking testbench for clock_calendar_set_editor: directed edits, idle timeout,
// random traffic with idling on both sides and backpressure, checked against a predictor.
// Depends on ccse_pkg and the clock_calendar_set_editor RTL only.
module clock_calendar_set_editor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Result fields, hour in the low bits.
    typedef struct packed {
        logic       timed_out;
        logic [4:0] hour_24;
        logic [2:0] selected;
        logic [6:0] year;
        logic [4:0] day;
        logic [3:0] month;
        logic       pm;
        logic [5:0] minute;
        logic [3:0] hour;
    } calendar_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [ccse_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [ccse_pkg::MODE_W-1:0]     s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [ccse_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted editor state
    logic [3:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic        cal_pm;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [6:0]  cal_year;
    ccse_pkg::sel_t cal_sel;
    logic [31:0] idle_ticks;
    logic [31:0] timeout_limit;

    calendar_view_t pending_views[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned hold_order = 0;
    int unsigned hold_taken = 0;
    int unsigned hold_left = 0;

    clock_calendar_set_editor i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic [6:0] y);
        logic [4:0] n;
        case (m)
            4'd2:                      n = (y % 7'd4 == 7'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    task automatic clamp_day();
        logic [4:0] n;
        n = month_days(cal_month, cal_year);
        if (cal_day > n)
            cal_day = n;
        if (cal_day < 5'd1)
            cal_day = 5'd1;
    endtask

    task automatic step_field(input bit go_up);
        case (cal_sel)
            ccse_pkg::SEL_HOUR:
                if (go_up)
                    cal_hour = (cal_hour >= 4'd12) ? 4'd1 : cal_hour + 4'd1;
                else
                    cal_hour = (cal_hour <= 4'd1) ? 4'd12 : cal_hour - 4'd1;
            ccse_pkg::SEL_MINUTE:
                if (go_up)
                    cal_minute = (cal_minute >= 6'd59) ? 6'd0 : cal_minute + 6'd1;
                else
                    cal_minute = (cal_minute == 6'd0) ? 6'd59 : cal_minute - 6'd1;
            ccse_pkg::SEL_PM:
                cal_pm = ~cal_pm;
            ccse_pkg::SEL_MONTH:
                if (go_up)
                    cal_month = (cal_month >= 4'd12) ? 4'd1 : cal_month + 4'd1;
                else
                    cal_month = (cal_month <= 4'd1) ? 4'd12 : cal_month - 4'd1;
            ccse_pkg::SEL_DAY:
                if (go_up)
                begin
                    if (cal_day >= month_days(cal_month, cal_year))
                    begin
                        cal_day = 5'd1;
                        if (cal_month >= 4'd12)
                        begin
                            cal_month = 4'd1;
                            if (cal_year < 7'd99)
                                cal_year = cal_year + 7'd1;
                        end
                        else
                            cal_month = cal_month + 4'd1;
                    end
                    else
                        cal_day = cal_day + 5'd1;
                end
                else
                begin
                    if (cal_day <= 5'd1)
                    begin
                        if (cal_month <= 4'd1)
                        begin
                            cal_month = 4'd12;
                            if (cal_year > 7'd0)
                                cal_year = cal_year - 7'd1;
                        end
                        else
                            cal_month = cal_month - 4'd1;
                        cal_day = month_days(cal_month, cal_year);
                    end
                    else
                        cal_day = cal_day - 5'd1;
                end
            ccse_pkg::SEL_YEAR:
                if (go_up)
                begin
                    if (cal_year < 7'd99)
                        cal_year = cal_year + 7'd1;
                end
                else
                begin
                    if (cal_year > 7'd0)
                        cal_year = cal_year - 7'd1;
                end
            default:
                ;
        endcase
        clamp_day();
    endtask

    // Apply one accepted item to the predicted state and queue the result it must give.
    task automatic advance_calendar(input logic [2:0] mode, input ccse_pkg::load_t ld);
        calendar_view_t view;
        case (mode)
            ccse_pkg::MODE_TICK:
                if (idle_ticks != 32'hFFFF_FFFF)
                    idle_ticks = idle_ticks + 32'd1;
            ccse_pkg::MODE_LEFT:
            begin
                cal_sel = (cal_sel == ccse_pkg::SEL_HOUR || cal_sel > ccse_pkg::SEL_YEAR)
                          ? ccse_pkg::SEL_YEAR : ccse_pkg::sel_t'(cal_sel - 3'd1);
                idle_ticks = '0;
            end
            ccse_pkg::MODE_RIGHT:
            begin
                cal_sel = (cal_sel >= ccse_pkg::SEL_YEAR) ? ccse_pkg::SEL_HOUR
                          : ccse_pkg::sel_t'(cal_sel + 3'd1);
                idle_ticks = '0;
            end
            ccse_pkg::MODE_UP:
            begin
                step_field(1'b1);
                idle_ticks = '0;
            end
            ccse_pkg::MODE_DOWN:
            begin
                step_field(1'b0);
                idle_ticks = '0;
            end
            ccse_pkg::MODE_LOAD:
            begin
                cal_hour = (ld.hour == 4'd0 || ld.hour > 4'd12) ? 4'd12 : ld.hour;
                cal_minute = (ld.minute > 6'd59) ? 6'd59 : ld.minute;
                cal_pm = ld.pm;
                cal_month = (ld.month == 4'd0) ? 4'd1 : (ld.month > 4'd12) ? 4'd12 : ld.month;
                cal_day = (ld.day == 5'd0) ? 5'd1 : ld.day;
                cal_year = (ld.year > 7'd99) ? 7'd99 : ld.year;
                clamp_day();
                idle_ticks = '0;
            end
            default:
                ;
        endcase
        view.hour = cal_hour;
        view.minute = cal_minute;
        view.pm = cal_pm;
        view.month = cal_month;
        view.day = cal_day;
        view.year = cal_year;
        view.selected = cal_sel;
        if (cal_pm)
            view.hour_24 = (cal_hour == 4'd12) ? 5'd12 : {1'b0, cal_hour} + 5'd12;
        else
            view.hour_24 = (cal_hour == 4'd12) ? 5'd0 : {1'b0, cal_hour};
        view.timed_out = (idle_ticks > timeout_limit);
        pending_views.push_back(view);
    endtask

    task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            mismatch_count++;
        end
    endtask

    task automatic compare_view(input calendar_view_t exp, input calendar_view_t act);
        check_field("hour", exp.hour, act.hour);
        check_field("minute", exp.minute, act.minute);
        check_field("pm", exp.pm, act.pm);
        check_field("month", exp.month, act.month);
        check_field("day", exp.day, act.day);
        check_field("year", exp.year, act.year);
        check_field("selected", exp.selected, act.selected);
        check_field("hour_24", exp.hour_24, act.hour_24);
        check_field("timed_out", exp.timed_out, act.timed_out);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_views.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                mismatch_count++;
            end
            else
                compare_view(pending_views.pop_front(), calendar_view_t'(m_axis_tdata[35:0]));
        end
    end

    // Result side: random stalls plus an occasional long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_order != hold_taken)
        begin
            hold_taken = hold_order;
            hold_left = hold_cycles;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("clock_calendar_set_editor test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] mode, input ccse_pkg::load_t ld);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, ld};
        s_axis_tuser <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_calendar(mode, ld);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] ticks);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        timeout_limit = ticks;
    endtask

    function automatic ccse_pkg::load_t clock_reading(input int unsigned h,
                                                      input int unsigned mi,
                                                      input int unsigned p,
                                                      input int unsigned mo,
                                                      input int unsigned d,
                                                      input int unsigned y);
        ccse_pkg::load_t ld;
        ld.hour = 4'(h);
        ld.minute = 6'(mi);
        ld.pm = 1'(p);
        ld.month = 4'(mo);
        ld.day = 5'(d);
        ld.year = 7'(y);
        return ld;
    endfunction

    function automatic ccse_pkg::load_t random_reading();
        logic [31:0] r;
        r = $urandom;
        return r[26:0];
    endfunction

    task automatic send_random_item();
        int unsigned r;
        logic [2:0] mode;
        ccse_pkg::load_t ld;
        r = $urandom_range(99);
        if (r < 18)
            mode = ccse_pkg::MODE_TICK;
        else if (r < 28)
            mode = ccse_pkg::MODE_LEFT;
        else if (r < 38)
            mode = ccse_pkg::MODE_RIGHT;
        else if (r < 62)
            mode = ccse_pkg::MODE_UP;
        else if (r < 86)
            mode = ccse_pkg::MODE_DOWN;
        else if (r < 97)
            mode = ccse_pkg::MODE_LOAD;
        else
            mode = r[0] ? MODE_SPARE_LO : MODE_SPARE_HI;
        // mostly plausible readings with days near month end and leap years
        if ($urandom_range(3) == 0)
            ld = random_reading();
        else
            ld = clock_reading($urandom_range(12, 1), $urandom_range(59), $urandom_range(1),
                               $urandom_range(12, 1),
                               $urandom_range(1) ? $urandom_range(31, 27) : $urandom_range(31, 1),
                               $urandom_range(1) ? 4 * $urandom_range(24) : $urandom_range(99));
        send_item(mode, ld);
    endtask

    task automatic test_directed_edits();
        send_item(ccse_pkg::MODE_TICK, random_reading());
        send_item(ccse_pkg::MODE_LEFT, random_reading());     // hour wraps to year
        send_item(ccse_pkg::MODE_DOWN, random_reading());     // year held at 0
        send_item(ccse_pkg::MODE_RIGHT, random_reading());    // year wraps to hour
        send_item(ccse_pkg::MODE_LOAD, clock_reading(15, 63, 1, 15, 31, 127));
        send_item(ccse_pkg::MODE_UP, random_reading());
        send_item(ccse_pkg::MODE_DOWN, random_reading());
        send_item(ccse_pkg::MODE_RIGHT, random_reading());
        send_item(ccse_pkg::MODE_UP, random_reading());
        send_item(ccse_pkg::MODE_DOWN, random_reading());
        send_item(ccse_pkg::MODE_RIGHT, random_reading());
        send_item(ccse_pkg::MODE_UP, random_reading());
        send_item(ccse_pkg::MODE_RIGHT, random_reading());
        send_item(ccse_pkg::MODE_UP, random_reading());
        send_item(ccse_pkg::MODE_DOWN, random_reading());
        send_item(ccse_pkg::MODE_RIGHT, random_reading());
        send_item(ccse_pkg::MODE_UP, random_reading());   // Dec 31 -> Jan 1, year held at 99
        send_item(ccse_pkg::MODE_DOWN, random_reading()); // back into previous year
        send_item(ccse_pkg::MODE_LOAD, clock_reading(0, 0, 0, 0, 0, 0));
        send_item(ccse_pkg::MODE_DOWN, random_reading()); // Jan 1 year 0 -> Dec 31 year 0
        send_item(ccse_pkg::MODE_LOAD, clock_reading(11, 30, 0, 2, 31, 4));
        send_item(ccse_pkg::MODE_UP, random_reading());   // Feb 29 -> Mar 1
        send_item(ccse_pkg::MODE_LOAD, clock_reading(1, 0, 1, 3, 31, 99));
        send_item(ccse_pkg::MODE_LEFT, random_reading());
        send_item(ccse_pkg::MODE_DOWN, random_reading()); // Mar 31 -> Feb, day clamped
        send_item(ccse_pkg::MODE_RIGHT, random_reading());
        send_item(ccse_pkg::MODE_RIGHT, random_reading());
        send_item(ccse_pkg::MODE_UP, random_reading());   // year held at 99
        send_item(MODE_SPARE_LO, random_reading());
        send_item(MODE_SPARE_HI, random_reading());
    endtask

    task automatic test_idle_timeout();
        wait_all_results();
        write_timeout(32'd0);
        send_item(ccse_pkg::MODE_TICK, random_reading());
        send_item(ccse_pkg::MODE_UP, random_reading());
        wait_all_results();
        write_timeout(32'hFFFF_FFFF);
        repeat (3) send_item(ccse_pkg::MODE_TICK, random_reading());
        wait_all_results();
        write_timeout(32'd2);
        repeat (4) send_item(ccse_pkg::MODE_TICK, random_reading());
        send_item(MODE_SPARE_LO, random_reading());
        send_item(ccse_pkg::MODE_LEFT, random_reading());
    endtask

    task automatic test_random_traffic(input int unsigned tx_idle, input int unsigned rx_idle,
                                       input int unsigned n_items, input logic [31:0] ticks);
        wait_all_results();
        write_timeout(ticks);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        repeat (n_items)
        begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(6, 1)) send_item(ccse_pkg::MODE_TICK, random_reading());
            else
                send_random_item();
        end
    endtask

    task automatic test_backpressure();
        wait_all_results();
        write_timeout($urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        hold_order++;
        repeat (40) send_random_item();
        wait_all_results();
        repeat (20) send_random_item();
    endtask

    initial
    begin
        cal_hour = 4'd12;
        cal_minute = '0;
        cal_pm = 1'b0;
        cal_month = 4'd1;
        cal_day = 5'd1;
        cal_year = '0;
        cal_sel = ccse_pkg::SEL_HOUR;
        idle_ticks = '0;
        timeout_limit = ccse_pkg::TIMEOUT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edits();
        test_idle_timeout();
        test_random_traffic(19, 52, 80, 32'd1);
        test_random_traffic(52, 19, 80, 32'd3);
        test_random_traffic(0, 0, 80, 32'($urandom_range(5)));
        test_backpressure();
        wait_all_results();
        if (mismatch_count == 0 && pending_views.size() == 0)
            $display("clock_calendar_set_editor test passed");
        else
            $display("clock_calendar_set_editor test failed");
        $finish;
    end

endmodule
